### hw/rtl/counting_bloom_filter_top_defines.svh
// Assertion macros for the counting Bloom filter RTL.
`ifndef COUNTING_BLOOM_FILTER_TOP_DEFINES_SVH
`define COUNTING_BLOOM_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cbf_pkg.sv
// Package: types, codes and defaults of the counting Bloom filter.
`default_nettype none

package cbf_pkg;

    localparam int unsigned TABLE_SIZE_DEF    = 1024;
    localparam int unsigned NUM_HASHES_DEF    = 3;
    localparam int unsigned COUNTER_WIDTH_DEF = 4;

    localparam int unsigned KEY_W  = 31;
    localparam int unsigned COEF_W = 31;
    localparam int unsigned OP_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [COEF_W-1:0] PRIME_MOD = 31'h7FFF_FFFF;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HASHES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_2   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_2 = 3'd6;

    localparam logic [1:0]        HASHES_RST   = 2'd3;
    localparam logic [COEF_W-1:0] MULT_0_RST   = 31'd48271;
    localparam logic [COEF_W-1:0] OFFSET_0_RST = 31'd1;
    localparam logic [COEF_W-1:0] MULT_1_RST   = 31'd16807;
    localparam logic [COEF_W-1:0] OFFSET_1_RST = 31'd2;
    localparam logic [COEF_W-1:0] MULT_2_RST   = 31'd69621;
    localparam logic [COEF_W-1:0] OFFSET_2_RST = 31'd3;

    // Travels with each hash through the pipeline.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            first;
        logic            last;
    } tag_t;

endpackage

`default_nettype wire

### hw/rtl/cbf_hash.sv
// Hash pipeline: ((mult*key + offset) mod 2^31-1) mod TABLE_SIZE, seven stages.
`default_nettype none

module cbf_hash
    import cbf_pkg::*;
#(
    parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
    localparam int unsigned IDX_W = $clog2(TABLE_SIZE)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire tag_t              in_tag,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [COEF_W-1:0] mult,
    input  wire logic [COEF_W-1:0] offset,
    output logic                   out_valid,
    output tag_t                   out_tag,
    output logic [IDX_W-1:0]       out_idx
);

    // Reciprocal for the table-size remainder: q estimate is q or q-1.
    localparam int unsigned SHIFT = 31 + IDX_W;
    localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(TABLE_SIZE);
    localparam logic [31:0] RECIP = RECIP_FULL[31:0];
    localparam int unsigned TS_W = IDX_W + 1;
    localparam logic [TS_W-1:0] TS = TS_W'(TABLE_SIZE);
    localparam int unsigned STAGES = 7;

    logic [STAGES-1:0] vld_reg;
    tag_t              tag_reg [STAGES];

    logic [61:0]       prod_reg;
    logic [COEF_W-1:0] off_reg;
    logic [61:0]       sum_reg;
    logic [31:0]       fold_reg;
    logic [30:0]       m3_reg;
    logic [30:0]       m4_reg;
    logic [62:0]       qp_reg;
    logic [30:0]       m5_reg;
    logic [30:0]       qt_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [31:0]       fold2;
    logic [30:0]       mod_p;
    logic [62:0]       q_full;
    logic [TS_W+30:0]  qt_full;
    logic [30:0]       rem;
    logic [30:0]       rem_fix;

    always_comb
    begin
        fold2 = {31'd0, fold_reg[31]} + {1'b0, fold_reg[30:0]};
        if (fold2 >= {1'b0, PRIME_MOD})
            mod_p = 31'(fold2 - {1'b0, PRIME_MOD});
        else
            mod_p = fold2[30:0];
        q_full  = qp_reg >> SHIFT;
        qt_full = (TS_W+31)'(q_full[30:0]) * (TS_W+31)'(TS);
        rem     = m5_reg - qt_reg;
        if (rem >= 31'(TABLE_SIZE))
            rem_fix = rem - 31'(TABLE_SIZE);
        else
            rem_fix = rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= in_tag;
            for (int i = 1; i < STAGES; i++)
                tag_reg[i] <= tag_reg[i-1];
            prod_reg <= 62'(mult) * 62'(key);
            off_reg  <= offset;
            sum_reg  <= prod_reg + {31'd0, off_reg};
            fold_reg <= {1'b0, sum_reg[61:31]} + {1'b0, sum_reg[30:0]};
            m3_reg   <= mod_p;
            qp_reg   <= 63'(m3_reg) * 63'(RECIP);
            m4_reg   <= m3_reg;
            qt_reg   <= qt_full[30:0];
            m5_reg   <= m4_reg;
            idx_reg  <= rem_fix[IDX_W-1:0];
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];
    assign out_idx   = idx_reg;

endmodule

`default_nettype wire

### hw/rtl/counting_bloom_filter_top.sv
// Top level: counting Bloom filter over one counter memory.
//
//  channel | dir | fields (lsb first)                       | transfer when
//  s_*     | in  | opcode[1:0], key[32:2]                   | s_tvalid & s_tready
//  m_*     | out | possibly_present[0], counter_saturated[1] | m_tvalid & m_tready
//  cfg_*   | in  | cfg_index selects register, cfg_data      | cfg_we
//
// An item holds the issue stage for one cycle per hash in use (1 to 3) unless stalled,
// and the next item can be accepted as its last hash issues. Each hash reads its counter
// once, and an insert or delete writes it back; m_tvalid is registered as the last hash
// leaves the counter stage. After reset a clearing pass zeroes the memory, s_tready low.
// A result waiting at m_* freezes the pipeline once the next one is done, until taken.
`default_nettype none
`include "counting_bloom_filter_top_defines.svh"

module counting_bloom_filter_top
    import cbf_pkg::*;
#(
    parameter int unsigned TABLE_SIZE    = TABLE_SIZE_DEF,
    parameter int unsigned NUM_HASHES    = NUM_HASHES_DEF,
    parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COEF_W-1:0]    cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [39:0]          s_tdata,   // opcode[1:0], key[32:2], zero[39:33]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata    // possibly_present[0], counter_saturated[1]
);

    localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
    localparam int unsigned CW    = COUNTER_WIDTH;

    // configuration
    logic [1:0]        hashes_reg;
    logic [COEF_W-1:0] mult_reg   [3];
    logic [COEF_W-1:0] offset_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hashes_reg    <= HASHES_RST;
            mult_reg[0]   <= MULT_0_RST;
            offset_reg[0] <= OFFSET_0_RST;
            mult_reg[1]   <= MULT_1_RST;
            offset_reg[1] <= OFFSET_1_RST;
            mult_reg[2]   <= MULT_2_RST;
            offset_reg[2] <= OFFSET_2_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HASHES:   hashes_reg    <= cfg_data[1:0];
                CFG_MULT_0:   mult_reg[0]   <= cfg_data;
                CFG_OFFSET_0: offset_reg[0] <= cfg_data;
                CFG_MULT_1:   mult_reg[1]   <= cfg_data;
                CFG_OFFSET_1: offset_reg[1] <= cfg_data;
                CFG_MULT_2:   mult_reg[2]   <= cfg_data;
                CFG_OFFSET_2: offset_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [1:0] nh_cfg;

    always_comb
    begin
        nh_cfg = (hashes_reg == 2'd0) ? 2'd1 : hashes_reg;
        if (nh_cfg > 2'(NUM_HASHES))
            nh_cfg = 2'(NUM_HASHES);
    end

    // clearing pass
    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == IDX_W'(TABLE_SIZE - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    // pipeline control
    logic             adv;
    logic             out_vld_reg;
    logic             m_vld_reg;
    tag_t             m_tag_reg;
    logic [IDX_W-1:0] m_idx_reg;

    // a finished result with the output still full holds everything
    assign adv = !(m_vld_reg && m_tag_reg.last && out_vld_reg && !m_tready);

    // issue stage
    logic              item_vld_reg;
    logic [OP_W-1:0]   item_op_reg;
    logic [KEY_W-1:0]  item_key_reg;
    logic [1:0]        hcnt_reg;
    logic [1:0]        nh_reg;
    logic              issue;
    logic              issue_last;
    logic              accept;
    tag_t              issue_tag;
    logic [COEF_W-1:0] sel_mult;
    logic [COEF_W-1:0] sel_offset;

    assign issue      = item_vld_reg && adv;
    assign issue_last = issue && (hcnt_reg == nh_reg - 2'd1);
    assign s_tready   = !clr_busy_reg && (!item_vld_reg || issue_last);
    assign accept     = s_tvalid && s_tready;

    always_comb
    begin
        issue_tag.op    = item_op_reg;
        issue_tag.first = (hcnt_reg == 2'd0);
        issue_tag.last  = (hcnt_reg == nh_reg - 2'd1);
        case (hcnt_reg)
            2'd0:
            begin
                sel_mult   = mult_reg[0];
                sel_offset = offset_reg[0];
            end
            2'd1:
            begin
                sel_mult   = mult_reg[1];
                sel_offset = offset_reg[1];
            end
            default:
            begin
                sel_mult   = mult_reg[2];
                sel_offset = offset_reg[2];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            hcnt_reg     <= 2'd0;
            nh_reg       <= 2'd1;
        end
        else if (accept)
        begin
            item_vld_reg <= 1'b1;
            hcnt_reg     <= 2'd0;
            nh_reg       <= nh_cfg;
        end
        else if (issue_last)
            item_vld_reg <= 1'b0;
        else if (issue)
            hcnt_reg <= hcnt_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_op_reg  <= s_tdata[1:0];
            item_key_reg <= s_tdata[32:2];
        end
    end

    // hashing
    logic             h_vld;
    tag_t             h_tag;
    logic [IDX_W-1:0] h_idx;

    cbf_hash #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (issue),
        .in_tag    (issue_tag),
        .key       (item_key_reg),
        .mult      (sel_mult),
        .offset    (sel_offset),
        .out_valid (h_vld),
        .out_tag   (h_tag),
        .out_idx   (h_idx)
    );

    // counter memory, read-modify-write
    logic [CW-1:0] mem [TABLE_SIZE];
    logic [CW-1:0] rdata_reg;
    logic          fwd_reg;
    logic [CW-1:0] fwd_data_reg;
    logic [CW-1:0] cur;
    logic [CW-1:0] new_val;
    logic          m_writes;
    logic          m_wr;
    logic          m_done;

    always_comb
    begin
        cur      = fwd_reg ? fwd_data_reg : rdata_reg;
        m_writes = (m_tag_reg.op == OP_INSERT) || (m_tag_reg.op == OP_DELETE);
        case (m_tag_reg.op)
            OP_INSERT: new_val = (cur == '1) ? cur : cur + CW'(1);
            OP_DELETE: new_val = (cur != '0) ? cur - CW'(1) : cur;
            default:   new_val = cur;
        endcase
    end

    assign m_done = adv && m_vld_reg;
    assign m_wr   = m_done && m_writes;

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_addr_reg] <= '0;
        else if (m_wr)
            mem[m_idx_reg] <= new_val;
    end

    always_ff @(posedge clk)
    begin
        if (adv && h_vld)
            rdata_reg <= mem[h_idx];
    end

    // same counter written in the cycle it is read: take the new value
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fwd_reg      <= m_wr && (m_idx_reg == h_idx);
            fwd_data_reg <= new_val;
            m_tag_reg    <= h_tag;
            m_idx_reg    <= h_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (adv)
            m_vld_reg <= h_vld;
    end

    // result gathering
    logic pres_acc_reg;
    logic sat_acc_reg;
    logic pres_now;
    logic sat_now;
    logic res_present_reg;
    logic res_sat_reg;

    always_comb
    begin
        pres_now = (m_tag_reg.first ? 1'b1 : pres_acc_reg) && (cur != '0);
        sat_now  = (m_tag_reg.first ? 1'b0 : sat_acc_reg)
                   || ((m_tag_reg.op == OP_INSERT) && (cur == '1));
    end

    always_ff @(posedge clk)
    begin
        if (m_done)
        begin
            pres_acc_reg <= pres_now;
            sat_acc_reg  <= sat_now;
            if (m_tag_reg.last)
            begin
                res_present_reg <= pres_now && (m_tag_reg.op == OP_QUERY);
                res_sat_reg     <= sat_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (m_done && m_tag_reg.last)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, res_sat_reg, res_present_reg};

    // checks
    `CBF_ASSERT_NOW(a_no_accept_clear, clr_busy_reg, !s_tready && !m_vld_reg, "accept or access during clearing pass")
    `CBF_ASSERT_NOW(a_hcnt_range, item_vld_reg, hcnt_reg < nh_reg, "hash counter beyond hash count")
    `CBF_ASSERT_NOW(a_nh_range, item_vld_reg, (nh_reg != 2'd0) && (nh_reg <= 2'(NUM_HASHES)), "hash count out of range")
    `CBF_ASSERT_NEXT(a_stall_freeze, !adv && item_vld_reg, $stable(m_idx_reg) && $stable(m_vld_reg) && $stable(hcnt_reg), "pipeline moved while stalled")

endmodule

`default_nettype wire
